FILE: sv/nsai_pkg.sv
// shared types and constants of the n-d slice address iterator
`default_nettype none

package nsai_pkg;

    // default configuration
    localparam int DIMS_DEFAULT  = 10;
    localparam int COORD_DEFAULT = 16;

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int DIMIDX_W = 4;
    localparam int CNT_W    = 4;
    localparam int OFF_W    = 32;

    // function codes of an input beat
    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD    = 2'd0,
        FN_BEGIN   = 2'd1,
        FN_ADVANCE = 2'd2
    } t_func;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COPY,
        ST_MAC,
        ST_STEP,
        ST_DONE
    } t_state;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic load;
        logic step;
    } t_mac_ctl;

    // write strobes of the bounds tables and coordinate store
    typedef struct packed {
        logic tbl_we;
        logic crd_we;
    } t_store_ctl;

    // status flags of a result beat
    typedef struct packed {
        logic status;
        logic ended;
        logic final_el;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/nsai_store.sv
// bounds tables and current coordinates, one shared read index
`default_nettype none

module nsai_store #(
    parameter int MAX_DIMS   = nsai_pkg::DIMS_DEFAULT,
    parameter int COORD_BITS = nsai_pkg::COORD_DEFAULT,
    localparam int IDX_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int CUR_W     = COORD_BITS + 1
) (
    input  wire                       i_clk,
    input  wire nsai_pkg::t_store_ctl i_ctl,
    input  wire [IDX_W-1:0]           i_tbl_idx,
    input  wire [COORD_BITS-1:0]      i_wr_start,
    input  wire [COORD_BITS-1:0]      i_wr_end,
    input  wire [COORD_BITS-1:0]      i_wr_limit,
    input  wire [IDX_W-1:0]           i_rd_idx,
    input  wire [CUR_W-1:0]           i_crd_wdata,
    output logic [COORD_BITS-1:0]     o_start,
    output logic [COORD_BITS-1:0]     o_end,
    output logic [COORD_BITS-1:0]     o_limit,
    output logic [CUR_W-1:0]          o_coord
);

    logic [COORD_BITS-1:0] r_start [MAX_DIMS];
    logic [COORD_BITS-1:0] r_end   [MAX_DIMS];
    logic [COORD_BITS-1:0] r_limit [MAX_DIMS];
    logic [CUR_W-1:0]      r_coord [MAX_DIMS];

    // table write from a load beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.tbl_we) begin
            r_start[i_tbl_idx] <= i_wr_start;
            r_end[i_tbl_idx]   <= i_wr_end;
            r_limit[i_tbl_idx] <= i_wr_limit;
        end
    end

    // coordinate write at the sequencer index
    always_ff @(posedge i_clk) begin
        if (i_ctl.crd_we) begin
            r_coord[i_rd_idx] <= i_crd_wdata;
        end
    end

    // single read index for all four stores
    assign o_start = r_start[i_rd_idx];
    assign o_end   = r_end[i_rd_idx];
    assign o_limit = r_limit[i_rd_idx];
    assign o_coord = r_coord[i_rd_idx];

endmodule

`default_nettype wire

FILE: sv/nsai_mac.sv
// shared multiply-accumulate for the horner offset sum
`default_nettype none

module nsai_mac #(
    parameter int COORD_BITS = nsai_pkg::COORD_DEFAULT,
    localparam int CUR_W     = COORD_BITS + 1,
    localparam int OFF_W     = nsai_pkg::OFF_W
) (
    input  wire                      i_clk,
    input  wire nsai_pkg::t_mac_ctl  i_ctl,
    input  wire [CUR_W-1:0]          i_coord,
    input  wire [COORD_BITS-1:0]     i_limit,
    output logic [OFF_W-1:0]         o_acc
);

    logic [OFF_W-1:0]   r_acc;
    logic [OFF_W-1:0]   n_acc;
    logic [OFF_W-1:0]   w_coord;
    logic [CUR_W-1:0]   w_len_full;
    logic [OFF_W-1:0]   w_len;
    logic [2*OFF_W-1:0] w_prod;

    // extent of the dimension and coordinate, both taken modulo 2^32
    assign w_len_full = {1'b0, i_limit} + CUR_W'(1);
    assign w_len      = OFF_W'(w_len_full);
    assign w_coord    = OFF_W'(i_coord);
    assign w_prod     = r_acc * w_len;

    // load sets acc = coord (over clear), clear sets 0, step does acc = acc * extent + coord
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.load) begin
            n_acc = w_coord;
        end else if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.step) begin
            n_acc = w_prod[OFF_W-1:0] + w_coord;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

FILE: sv/nsai_seq.sv
// sequencer: validation, start copy, offset pass and odometer carry pass
`default_nettype none

module nsai_seq #(
    parameter int MAX_DIMS   = nsai_pkg::DIMS_DEFAULT,
    parameter int COORD_BITS = nsai_pkg::COORD_DEFAULT,
    localparam int IDX_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int CUR_W     = COORD_BITS + 1
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire [nsai_pkg::FUNC_W-1:0]  i_func,
    input  wire [nsai_pkg::DIMIDX_W-1:0] i_dim_index,
    input  wire [nsai_pkg::CNT_W-1:0]   i_dim_count,
    input  wire [COORD_BITS-1:0]        i_start,
    input  wire [COORD_BITS-1:0]        i_end,
    input  wire [COORD_BITS-1:0]        i_limit,
    input  wire [CUR_W-1:0]             i_coord,
    input  wire                         i_slot_free,
    output logic [IDX_W-1:0]            o_rd_idx,
    output logic [IDX_W-1:0]            o_tbl_idx,
    output nsai_pkg::t_store_ctl        o_store_ctl,
    output logic [CUR_W-1:0]            o_crd_wdata,
    output nsai_pkg::t_mac_ctl          o_mac_ctl,
    output logic                        o_res_wr,
    output nsai_pkg::t_result           o_res
);

    nsai_pkg::t_state  r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_chk_last, n_chk_last;
    logic [IDX_W-1:0]  r_act_last, n_act_last;
    logic              r_carry, n_carry;
    logic              r_over, n_over;
    nsai_pkg::t_result r_res, n_res;

    logic              w_accept;
    logic              w_cnt_bad;
    logic              w_c_past_end;
    logic              w_bad_dim;
    logic [CUR_W-1:0]  w_bump;
    logic              w_bump_past_end;
    logic [CUR_W-1:0]  w_end_ext;

    assign o_in_ready = (r_state == nsai_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // shared compares on the entry under the read index and on the beat's count
    assign w_end_ext       = {1'b0, i_end};
    assign w_cnt_bad       = (i_dim_count == '0) || (int'(i_dim_count) > MAX_DIMS);
    assign w_c_past_end    = i_coord > w_end_ext;
    assign w_bad_dim       = (i_end < i_start) || (i_end > i_limit);
    assign w_bump          = i_coord + {{COORD_BITS{1'b0}}, r_carry};
    assign w_bump_past_end = w_bump > w_end_ext;

    // idle reads dimension 0 for the end-of-slice check
    assign o_rd_idx  = (r_state == nsai_pkg::ST_IDLE) ? '0 : r_idx;
    assign o_tbl_idx = i_dim_index[IDX_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nsai_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = nsai_pkg::ST_DONE;
                    if (i_func == nsai_pkg::FN_BEGIN) begin
                        if (!w_cnt_bad) begin
                            n_state = nsai_pkg::ST_CHECK;
                        end
                    end else if (i_func == nsai_pkg::FN_ADVANCE) begin
                        if (!(r_over || w_c_past_end)) begin
                            n_state = (r_act_last == '0) ? nsai_pkg::ST_STEP
                                                         : nsai_pkg::ST_MAC;
                        end
                    end
                end
            end
            nsai_pkg::ST_CHECK: begin
                if (w_bad_dim) begin
                    n_state = nsai_pkg::ST_DONE;
                end else if (r_idx == r_chk_last) begin
                    n_state = nsai_pkg::ST_COPY;
                end
            end
            nsai_pkg::ST_COPY: begin
                if (r_idx == r_chk_last) begin
                    n_state = nsai_pkg::ST_DONE;
                end
            end
            nsai_pkg::ST_MAC: begin
                if (r_idx == r_act_last) begin
                    n_state = nsai_pkg::ST_STEP;
                end
            end
            nsai_pkg::ST_STEP: begin
                if (r_idx == '0) begin
                    n_state = nsai_pkg::ST_DONE;
                end
            end
            nsai_pkg::ST_DONE: begin
                if (i_slot_free) begin
                    n_state = nsai_pkg::ST_IDLE;
                end
            end
            default: n_state = nsai_pkg::ST_IDLE;
        endcase
    end

    // datapath control and next register values
    always_comb begin
        n_idx       = r_idx;
        n_chk_last  = r_chk_last;
        n_act_last  = r_act_last;
        n_carry     = r_carry;
        n_over      = r_over;
        n_res       = r_res;
        o_store_ctl = '0;
        o_mac_ctl   = '0;
        o_crd_wdata = i_coord;
        o_res_wr    = 1'b0;
        unique case (r_state)
            nsai_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_res         = '0;
                    o_mac_ctl.clr = 1'b1;
                    n_idx         = '0;
                    unique case (i_func)
                        nsai_pkg::FN_LOAD: begin
                            o_store_ctl.tbl_we = int'(i_dim_index) < MAX_DIMS;
                            n_res.ended        = r_over;
                        end
                        nsai_pkg::FN_BEGIN: begin
                            n_chk_last = IDX_W'(i_dim_count - nsai_pkg::CNT_W'(1));
                            if (w_cnt_bad) begin
                                n_res.status = 1'b1;
                                n_res.ended  = 1'b1;
                                n_over       = 1'b1;
                            end
                        end
                        nsai_pkg::FN_ADVANCE: begin
                            if (r_over || w_c_past_end) begin
                                n_res.ended = 1'b1;
                            end else begin
                                o_mac_ctl.load = 1'b1;
                                n_carry        = 1'b1;
                                n_idx          = (r_act_last == '0) ? '0 : IDX_W'(1);
                            end
                        end
                        default: n_res.ended = r_over;
                    endcase
                end
            end
            nsai_pkg::ST_CHECK: begin
                if (w_bad_dim) begin
                    n_res.status = 1'b1;
                    n_res.ended  = 1'b1;
                    n_over       = 1'b1;
                end else if (r_idx == r_chk_last) begin
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            nsai_pkg::ST_COPY: begin
                o_store_ctl.crd_we = 1'b1;
                o_crd_wdata        = {1'b0, i_start};
                if (r_idx == r_chk_last) begin
                    n_act_last = r_chk_last;
                    n_over     = 1'b0;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            nsai_pkg::ST_MAC: begin
                o_mac_ctl.step = 1'b1;
                if (r_idx != r_act_last) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            nsai_pkg::ST_STEP: begin
                // odometer carry, innermost dimension first
                o_store_ctl.crd_we = 1'b1;
                if (r_idx == '0) begin
                    o_crd_wdata = w_bump;
                    if (w_bump_past_end) begin
                        n_res.final_el = 1'b1;
                        n_over         = 1'b1;
                    end
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                    if (w_bump_past_end) begin
                        o_crd_wdata = {1'b0, i_start};
                        n_carry     = 1'b1;
                    end else begin
                        o_crd_wdata = w_bump;
                        n_carry     = 1'b0;
                    end
                end
            end
            nsai_pkg::ST_DONE: begin
                o_res_wr = i_slot_free;
            end
            default: n_idx = r_idx;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= nsai_pkg::ST_IDLE;
            r_over     <= 1'b1;
            r_act_last <= '0;
        end else begin
            r_state    <= n_state;
            r_over     <= n_over;
            r_act_last <= n_act_last;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_chk_last <= n_chk_last;
        r_carry    <= n_carry;
        r_res      <= n_res;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: sv/nd_slice_address_iterator_top.sv
// top level of the n-d slice address iterator
//
// Input channel i_in_valid/o_in_ready carries one beat with func, dim_index,
// dim_start, dim_end, dim_limit and dim_count. Output channel
// o_out_valid/i_out_ready returns exactly one result beat per input beat.
// A load beat writes one dimension's bounds; a begin beat validates the
// descriptor and places the coordinates at the slice starts; an advance
// beat returns the row-major element offset and steps the coordinates.
// Work from accept to result valid, n being the dimension count:
//   load, unused code, ended advance, bad count: no pass, result at once
//   begin: a check pass over n dims, then a copy pass if all are valid
//   advance: n-1 steps of the shared multiply-accumulate, then
//   n steps of the odometer carry from the innermost dimension
// The input side is not ready while a beat is being worked on, so a
// new beat is accepted only after the last one's result is written.
// A finished result sits in an output register; the next input beat is
// accepted while it waits, and a stalled receiver only holds the sequencer
// once its next result is ready. Reset empties the output register and
// leaves the iteration ended; the bounds tables are undefined until loaded.
`default_nettype none

module nd_slice_address_iterator_top #(
    parameter int MAX_DIMS   = nsai_pkg::DIMS_DEFAULT,
    parameter int COORD_BITS = nsai_pkg::COORD_DEFAULT
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire [nsai_pkg::FUNC_W-1:0]    i_func,
    input  wire [nsai_pkg::DIMIDX_W-1:0]  i_dim_index,
    input  wire [COORD_BITS-1:0]          i_dim_start,
    input  wire [COORD_BITS-1:0]          i_dim_end,
    input  wire [COORD_BITS-1:0]          i_dim_limit,
    input  wire [nsai_pkg::CNT_W-1:0]     i_dim_count,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic                          o_status,
    output logic [nsai_pkg::OFF_W-1:0]    o_element_offset,
    output logic                          o_ended,
    output logic                          o_final_element
);

    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CUR_W = COORD_BITS + 1;

    logic [IDX_W-1:0]            w_rd_idx;
    logic [IDX_W-1:0]            w_tbl_idx;
    nsai_pkg::t_store_ctl        w_store_ctl;
    nsai_pkg::t_mac_ctl          w_mac_ctl;
    logic [CUR_W-1:0]            w_crd_wdata;
    logic [COORD_BITS-1:0]       w_start;
    logic [COORD_BITS-1:0]       w_end;
    logic [COORD_BITS-1:0]       w_limit;
    logic [CUR_W-1:0]            w_coord;
    logic [nsai_pkg::OFF_W-1:0]  w_acc;
    logic                        w_res_wr;
    nsai_pkg::t_result           w_res;
    logic                        w_slot_free;

    logic                        r_out_valid;
    logic                        r_status;
    logic [nsai_pkg::OFF_W-1:0]  r_offset;
    logic                        r_ended;
    logic                        r_final;

    nsai_seq #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_dim_index (i_dim_index),
        .i_dim_count (i_dim_count),
        .i_start     (w_start),
        .i_end       (w_end),
        .i_limit     (w_limit),
        .i_coord     (w_coord),
        .i_slot_free (w_slot_free),
        .o_rd_idx    (w_rd_idx),
        .o_tbl_idx   (w_tbl_idx),
        .o_store_ctl (w_store_ctl),
        .o_crd_wdata (w_crd_wdata),
        .o_mac_ctl   (w_mac_ctl),
        .o_res_wr    (w_res_wr),
        .o_res       (w_res)
    );

    nsai_store #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (w_store_ctl),
        .i_tbl_idx   (w_tbl_idx),
        .i_wr_start  (i_dim_start),
        .i_wr_end    (i_dim_end),
        .i_wr_limit  (i_dim_limit),
        .i_rd_idx    (w_rd_idx),
        .i_crd_wdata (w_crd_wdata),
        .o_start     (w_start),
        .o_end       (w_end),
        .o_limit     (w_limit),
        .o_coord     (w_coord)
    );

    nsai_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctl   (w_mac_ctl),
        .i_coord (w_coord),
        .i_limit (w_limit),
        .o_acc   (w_acc)
    );

    // output register frees when empty or taken this cycle
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_res_wr) begin
            r_status <= w_res.status;
            r_offset <= w_acc;
            r_ended  <= w_res.ended;
            r_final  <= w_res.final_el;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_element_offset = r_offset;
    assign o_ended          = r_ended;
    assign o_final_element  = r_final;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// testbench of the n-d slice address iterator: random beats, offset predictor, result checks
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIMS    = nsai_pkg::DIMS_DEFAULT;
    localparam int COORD_BITS  = nsai_pkg::COORD_DEFAULT;
    localparam int BEAT_TARGET = 850;
    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int PRINT_CAP   = 40;

    // func code the block leaves unused
    localparam logic [nsai_pkg::FUNC_W-1:0] FN_SPARE = 2'd3;

    // one input beat
    typedef struct packed {
        logic [nsai_pkg::FUNC_W-1:0]   func;
        logic [nsai_pkg::DIMIDX_W-1:0] idx;
        logic [COORD_BITS-1:0]         first;
        logic [COORD_BITS-1:0]         last;
        logic [COORD_BITS-1:0]         lim;
        logic [nsai_pkg::CNT_W-1:0]    cnt;
    } t_slice_beat;

    // one result beat
    typedef struct packed {
        logic                       status;
        logic [nsai_pkg::OFF_W-1:0] offset;
        logic                       ended;
        logic                       final_el;
    } t_walk_result;

    // receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MASK,
        RX_COIN
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    logic [nsai_pkg::FUNC_W-1:0]   i_func = '0;
    logic [nsai_pkg::DIMIDX_W-1:0] i_dim_index = '0;
    logic [COORD_BITS-1:0]         i_dim_start = '0;
    logic [COORD_BITS-1:0]         i_dim_end = '0;
    logic [COORD_BITS-1:0]         i_dim_limit = '0;
    logic [nsai_pkg::CNT_W-1:0]    i_dim_count = '0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic                          o_status;
    logic [nsai_pkg::OFF_W-1:0]    o_element_offset;
    logic                          o_ended;
    logic                          o_final_element;

    nd_slice_address_iterator_top #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_dim_index      (i_dim_index),
        .i_dim_start      (i_dim_start),
        .i_dim_end        (i_dim_end),
        .i_dim_limit      (i_dim_limit),
        .i_dim_count      (i_dim_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_element_offset (o_element_offset),
        .o_ended          (o_ended),
        .o_final_element  (o_final_element)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow state of the iterator
    bit [COORD_BITS-1:0] lo_tab  [MAX_DIMS];
    bit [COORD_BITS-1:0] hi_tab  [MAX_DIMS];
    bit [COORD_BITS-1:0] lim_tab [MAX_DIMS];
    bit [COORD_BITS:0]   coord   [MAX_DIMS];
    int unsigned         n_active = 0;
    bit                  walk_done = 1'b1;

    t_slice_beat  beat_q[$];
    t_walk_result offset_q[$];
    t_slice_beat  cur_beat;

    int  n_effective = 0;
    int  errors = 0;
    int  results_done = 0;
    int  n_elems = 0;
    int  n_final = 0;
    int  n_invalid = 0;
    int  cycles = 0;
    bit  run_ok = 1'b0;
    bit  took_in = 1'b0;

    // sender burst shaping
    int  burst_left = 0;
    int  gap_left = 0;

    // receiver stall shaping
    t_rx_mode rx_mode = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_used = 1'b0;
    bit [7:0] stall_mask = 8'hff;
    bit [2:0] mask_phase = '0;

    // expected result of one beat, updating the shadow state
    function automatic t_walk_result predict_walk(t_slice_beat b);
        t_walk_result r;
        bit           ok;
        int           i;
        int unsigned  n;
        bit [31:0]    acc;
        bit [31:0]    prod;
        r = '0;
        case (b.func)
            nsai_pkg::FN_LOAD: begin
                if (b.idx < MAX_DIMS) begin
                    lo_tab[b.idx]  = b.first;
                    hi_tab[b.idx]  = b.last;
                    lim_tab[b.idx] = b.lim;
                end
                r.ended = walk_done;
            end
            nsai_pkg::FN_BEGIN: begin
                ok = (b.cnt >= 1) && (b.cnt <= MAX_DIMS);
                if (ok) begin
                    for (i = 0; i < b.cnt; i++) begin
                        if (hi_tab[i] < lo_tab[i] || hi_tab[i] > lim_tab[i]) ok = 1'b0;
                    end
                end
                if (ok) begin
                    for (i = 0; i < b.cnt; i++) coord[i] = {1'b0, lo_tab[i]};
                    n_active  = 32'(b.cnt);
                    walk_done = 1'b0;
                end else begin
                    walk_done = 1'b1;
                    r.status  = 1'b1;
                    r.ended   = 1'b1;
                end
            end
            nsai_pkg::FN_ADVANCE: begin
                if (walk_done || coord[0] > hi_tab[0]) begin
                    r.ended = 1'b1;
                end else begin
                    n = (n_active < 1) ? 1 : (n_active > MAX_DIMS) ? MAX_DIMS : n_active;
                    // row-major offset, wrapping at 32 bits
                    acc  = 32'(coord[n-1]);
                    prod = 32'd1;
                    for (i = n - 1; i > 0; i--) begin
                        prod = prod * (32'(lim_tab[i]) + 32'd1);
                        acc  = acc + 32'(coord[i-1]) * prod;
                    end
                    r.offset = acc;
                    // odometer step from the innermost dimension
                    coord[n-1] = coord[n-1] + 1'b1;
                    for (i = n - 1; i > 0; i--) begin
                        if (coord[i] > hi_tab[i]) begin
                            coord[i]   = {1'b0, lo_tab[i]};
                            coord[i-1] = coord[i-1] + 1'b1;
                        end
                    end
                    if (coord[0] > hi_tab[0]) begin
                        r.final_el = 1'b1;
                        walk_done  = 1'b1;
                    end
                end
            end
            default: begin
                r.ended = walk_done;
            end
        endcase
        return r;
    endfunction

    // beat with every field but func random; func is the unused code
    function automatic t_slice_beat any_beat();
        t_slice_beat b;
        b.func  = FN_SPARE;
        b.idx   = nsai_pkg::DIMIDX_W'($urandom);
        b.first = COORD_BITS'($urandom);
        b.last  = COORD_BITS'($urandom);
        b.lim   = COORD_BITS'($urandom);
        b.cnt   = nsai_pkg::CNT_W'($urandom);
        return b;
    endfunction

    function automatic t_slice_beat load_beat(int idx, bit [15:0] first, bit [15:0] last,
                                              bit [15:0] lim);
        t_slice_beat b;
        b       = any_beat();
        b.func  = nsai_pkg::FN_LOAD;
        b.idx   = nsai_pkg::DIMIDX_W'(idx);
        b.first = first;
        b.last  = last;
        b.lim   = lim;
        return b;
    endfunction

    function automatic t_slice_beat begin_beat(int cnt);
        t_slice_beat b;
        b      = any_beat();
        b.func = nsai_pkg::FN_BEGIN;
        b.cnt  = nsai_pkg::CNT_W'(cnt);
        return b;
    endfunction

    function automatic t_slice_beat step_beat();
        t_slice_beat b;
        b      = any_beat();
        b.func = nsai_pkg::FN_ADVANCE;
        return b;
    endfunction

    // greatest legal coordinate for a slice of the given span
    function automatic bit [15:0] pick_limit(int span);
        case ($urandom_range(0, 3))
            0:       return 16'(span);
            1:       return 16'hffff;
            2:       return 16'($urandom_range(span, 16'hffff));
            default: return 16'(span + $urandom_range(0, 5));
        endcase
    endfunction

    task automatic add_beat(t_slice_beat b);
        beat_q.push_back(b);
        if (!(b.func == FN_SPARE || (b.func == nsai_pkg::FN_LOAD && b.idx >= MAX_DIMS)))
            n_effective++;
    endtask

    // load a descriptor, begin, then walk it; broken puts one bad dimension in
    task automatic gen_walk(bit broken);
        int        n, budget, span, bad, steps, elems, i, k;
        bit [15:0] lim, lo, hi;
        n      = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_DIMS)
                                             : $urandom_range(1, 4);
        budget = $urandom_range(1, 24);
        elems  = 1;
        bad    = $urandom_range(0, n - 1);
        for (i = 0; i < n; i++) begin
            span   = (budget >= 3) ? $urandom_range(0, 2)
                   : (budget == 2) ? $urandom_range(0, 1) : 0;
            budget = budget / (span + 1);
            elems  = elems * (span + 1);
            lim    = pick_limit(span);
            lo     = ($urandom_range(0, 4) == 0) ? 16'(lim - span)
                                                 : 16'($urandom_range(0, lim - span));
            if (broken && i == bad) begin
                if ($urandom_range(0, 1)) begin
                    // start past end
                    hi = 16'($urandom_range(0, 16'hfffe));
                    lo = 16'($urandom_range(hi + 1, 16'hffff));
                    add_beat(load_beat(i, lo, hi, 16'($urandom)));
                end else begin
                    // end past limit
                    lim = 16'($urandom_range(0, 16'hfffe));
                    hi  = 16'($urandom_range(lim + 1, 16'hffff));
                    add_beat(load_beat(i, 16'($urandom_range(0, hi)), hi, lim));
                end
            end else begin
                add_beat(load_beat(i, lo, 16'(lo + span), lim));
            end
        end
        add_beat(begin_beat(n));
        if (broken) begin
            steps = $urandom_range(1, 2);
        end else if ($urandom_range(0, 6) == 0) begin
            steps = $urandom_range(1, elems);
        end else begin
            steps = elems + $urandom_range(0, 2);
        end
        for (k = 0; k < steps; k++) begin
            add_beat(step_beat());
            case ($urandom_range(0, 49))
                0: begin
                    // bounds changed under a running walk
                    span = $urandom_range(0, 2);
                    lim  = pick_limit(span);
                    lo   = 16'($urandom_range(0, lim - span));
                    add_beat(load_beat($urandom_range(0, n - 1), lo, 16'(lo + span), lim));
                end
                1: add_beat(any_beat());
                default: ;
            endcase
        end
    endtask

    // mismatch report
    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        if (errors < PRINT_CAP)
            $display("mismatch on %s at result %0d: got %0h, want %0h",
                     what, results_done, got, want);
        errors++;
    endtask

    // sender: bursts of beats with random gaps
    always @(negedge i_clk) begin
        if (run_ok && !(i_in_valid && !took_in)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (beat_q.size() > 0) begin
                cur_beat = beat_q.pop_front();
                i_func      <= cur_beat.func;
                i_dim_index <= cur_beat.idx;
                i_dim_start <= cur_beat.first;
                i_dim_end   <= cur_beat.last;
                i_dim_limit <= cur_beat.lim;
                i_dim_count <= cur_beat.cnt;
                i_in_valid  <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall styles that change at random, plus one long hold-off
    always @(negedge i_clk) begin
        if (!run_ok) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_used && results_done >= HOLD_AFTER) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode    = t_rx_mode'($urandom_range(0, 2));
                stall_mask = 8'($urandom) | 8'h01;
                mode_left  = $urandom_range(32, 63);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN: i_out_ready <= 1'b1;
                RX_MASK: begin
                    i_out_ready <= stall_mask[mask_phase];
                    mask_phase = mask_phase + 1'b1;
                end
                default: i_out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // accepted beats feed the predictor, result beats are checked in order
    always @(posedge i_clk) begin
        t_walk_result want;
        took_in <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (offset_q.size() == 0) begin
                report("unexpected result beat", o_element_offset, 32'd0);
            end else begin
                want = offset_q.pop_front();
                if (o_status !== want.status)
                    report("status", 32'(o_status), 32'(want.status));
                if (o_element_offset !== want.offset)
                    report("element offset", o_element_offset, want.offset);
                if (o_ended !== want.ended)
                    report("ended", 32'(o_ended), 32'(want.ended));
                if (o_final_element !== want.final_el)
                    report("final element", 32'(o_final_element), 32'(want.final_el));
                if (want.status) n_invalid++;
                if (want.final_el) n_final++;
            end
            results_done++;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            want = predict_walk(cur_beat);
            if (cur_beat.func == nsai_pkg::FN_ADVANCE && !want.ended) n_elems++;
            offset_q.push_back(want);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, offset_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int d;
        // directed: every dimension loaded before anything reads the tables
        add_beat(load_beat(0, 16'h0000, 16'h0000, 16'h0000));
        add_beat(step_beat());
        add_beat(any_beat());
        add_beat(load_beat(15, 16'hffff, 16'hffff, 16'hffff));
        add_beat(load_beat(10, 16'h0001, 16'h0002, 16'h0003));
        for (d = 1; d < MAX_DIMS - 1; d++)
            add_beat(load_beat(d, 16'h0000, (d == 4) ? 16'h0001 : 16'h0000,
                               (d == 3) ? 16'hffff : 16'(d + 1)));
        add_beat(load_beat(MAX_DIMS - 1, 16'hffff, 16'hffff, 16'hffff));
        add_beat(begin_beat(0));
        add_beat(begin_beat(15));
        add_beat(begin_beat(MAX_DIMS));
        repeat (3) add_beat(step_beat());
        add_beat(load_beat(2, 16'h0005, 16'h0004, 16'h0009));
        add_beat(begin_beat(3));
        add_beat(load_beat(2, 16'h0000, 16'h0005, 16'h0004));
        add_beat(begin_beat(3));
        add_beat(step_beat());

        // random: mostly well-formed walks, some noise and broken descriptors
        while (n_effective < BEAT_TARGET) begin
            d = $urandom_range(0, 99);
            if (d < 70) begin
                gen_walk(1'b0);
            end else if (d < 85) begin
                case ($urandom_range(0, 3))
                    0: add_beat(load_beat($urandom_range(0, 15), 16'($urandom),
                                          16'($urandom), 16'($urandom)));
                    1: add_beat(begin_beat($urandom_range(0, 15)));
                    2: add_beat(step_beat());
                    default: add_beat(any_beat());
                endcase
            end else begin
                gen_walk(1'b1);
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_ok = 1'b1;

        while (beat_q.size() != 0 || i_in_valid) @(negedge i_clk);
        while (offset_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("checked %0d result beats from %0d working beats in %0d cycles",
                 results_done, n_effective, cycles);
        $display("%0d slice elements walked, %0d walks completed, %0d descriptors rejected",
                 n_elems, n_final, n_invalid);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
